@@ rtl/xtea_pkg.sv @@
// xtea_pkg: shared types, constants and helper functions for the xtea cipher unit
// depends on nothing; imported by every module of the block but xtea_checker
package xtea_pkg;

   // number of full cycles (two half-rounds each) by default
   localparam int DEFAULT_CYCLE_COUNT = 32;

   // round constant
   localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

   // configuration register indexes
   localparam logic [1:0] KEY_WORD0_IDX = 2'd0;
   localparam logic [1:0] KEY_WORD1_IDX = 2'd1;
   localparam logic [1:0] KEY_WORD2_IDX = 2'd2;
   localparam logic [1:0] KEY_WORD3_IDX = 2'd3;

   // key register reset values
   localparam logic [31:0] KEY_WORD0_RESET = 32'h1A6B_6450;
   localparam logic [31:0] KEY_WORD1_RESET = 32'h69D7_4842;
   localparam logic [31:0] KEY_WORD2_RESET = 32'h2BC7_9044;
   localparam logic [31:0] KEY_WORD3_RESET = 32'h4EF3_10BC;

   // apb address width: four registers at byte offsets 0, 4, 8, 12
   localparam int CSR_ADDR_WIDTH = 4;

   // full 128-bit key, word 0 at index 0
   typedef logic [3:0][31:0] key_type;

   // one data word moving down the round pipeline
   typedef struct packed {
      logic        action;
      logic [31:0] first_word;
      logic [31:0] second_word;
   } word_type;

   // one result word
   typedef struct packed {
      logic [31:0] first_word;
      logic [31:0] second_word;
   } block_type;

   // running sum after a given count of delta additions, modulo 2^32
   function automatic logic [31:0] round_sum(input int unsigned count);
      logic [63:0] prod;
      prod = 64'(XTEA_DELTA) * 64'(count);
      return prod[31:0];
   endfunction

   // feistel mixing of one half
   function automatic logic [31:0] mix_word(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

@@ rtl/xtea_block_cipher_unit.sv @@
// xtea_block_cipher_unit: top level of the pipelined xtea cipher
// depends on xtea_pkg, xtea_csr, xtea_round and xtea_skid
//
// usage:
//   request channel (req_valid/req_ready) carries one 64-bit block as two
//   32-bit words plus req_action (0 encrypt, 1 decrypt). response channel
//   (rsp_valid/rsp_ready) returns the two transformed words, in order.
//   the 128-bit key lives in four apb registers at byte offsets 0, 4, 8, 12;
//   write them only while no word is in flight.
// pipeline and throughput:
//   from acceptance to rsp_valid a word passes one register stage per
//   feistel half-round plus the output register. one word enters and one
//   leaves per cycle while the receiver does not stall.
// reset:
//   synchronous; clears all stage valid bits and the output buffer and
//   loads the built-in key.
// receiver stall:
//   the output register plus one skid entry absorb a stall; once the skid
//   entry fills, req_ready drops and the whole round pipeline holds.
module xtea_block_cipher_unit #(
   parameter int CYCLE_COUNT = xtea_pkg::DEFAULT_CYCLE_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [31:0]                         req_first_word,
   input  logic [31:0]                         req_second_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         rsp_out_first_word,
   output logic [31:0]                         rsp_out_second_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [xtea_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import xtea_pkg::*;

   localparam int STAGES = 2 * CYCLE_COUNT;

   key_type   key;
   logic      advance;
   logic      stage_valid [0:STAGES];
   word_type  stage_word  [0:STAGES];
   block_type last_block;
   block_type out_block;

   // key registers
   xtea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .key     (key)
   );

   // pipeline input
   assign stage_valid[0]            = req_valid;
   assign stage_word[0].action      = req_action;
   assign stage_word[0].first_word  = req_first_word;
   assign stage_word[0].second_word = req_second_word;

   // one register stage per half-round
   for (genvar g = 0; g < STAGES; g++) begin : g_round
      xtea_round #(
         .HALF_STEP (g),
         .CYCLES    (CYCLE_COUNT)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[g]),
         .in_word   (stage_word[g]),
         .key       (key),
         .out_valid (stage_valid[g+1]),
         .out_word  (stage_word[g+1])
      );
   end

   assign last_block.first_word  = stage_word[STAGES].first_word;
   assign last_block.second_word = stage_word[STAGES].second_word;

   // output buffer; its ready moves the whole pipeline
   xtea_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[STAGES]),
      .in_block  (last_block),
      .in_ready  (advance),
      .out_valid (rsp_valid),
      .out_block (out_block),
      .out_ready (rsp_ready)
   );

   assign req_ready           = advance;
   assign rsp_out_first_word  = out_block.first_word;
   assign rsp_out_second_word = out_block.second_word;

endmodule

@@ rtl/xtea_csr.sv @@
// xtea_csr: apb-style register file holding the four key words
// depends on xtea_pkg
module xtea_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [xtea_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output xtea_pkg::key_type                   key
);
   import xtea_pkg::*;

   key_type    key_ff;
   key_type    key_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en   = psel & penable & pwrite;

   // key register write decode
   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         case (reg_idx)
            KEY_WORD0_IDX: key_in[0] = pwdata;
            KEY_WORD1_IDX: key_in[1] = pwdata;
            KEY_WORD2_IDX: key_in[2] = pwdata;
            KEY_WORD3_IDX: key_in[3] = pwdata;
            default:       key_in    = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= KEY_WORD0_RESET;
         key_ff[1] <= KEY_WORD1_RESET;
         key_ff[2] <= KEY_WORD2_RESET;
         key_ff[3] <= KEY_WORD3_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         KEY_WORD0_IDX: prdata = key_ff[0];
         KEY_WORD1_IDX: prdata = key_ff[1];
         KEY_WORD2_IDX: prdata = key_ff[2];
         KEY_WORD3_IDX: prdata = key_ff[3];
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign key    = key_ff;

endmodule

@@ rtl/xtea_round.sv @@
// xtea_round: one registered feistel half-round, encrypt or decrypt per word
// depends on xtea_pkg; sum and key index are fixed by the stage position
module xtea_round #(
   parameter int HALF_STEP = 0,
   parameter int CYCLES    = xtea_pkg::DEFAULT_CYCLE_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  xtea_pkg::word_type  in_word,
   input  xtea_pkg::key_type   key,
   output logic                out_valid,
   output xtea_pkg::word_type  out_word
);
   import xtea_pkg::*;

   localparam int STEP_IDX = HALF_STEP / 2;
   localparam bit IS_ODD   = (HALF_STEP % 2) == 1;
   localparam logic [31:0] ENC_SUM =
      round_sum(IS_ODD ? STEP_IDX + 1 : STEP_IDX);
   localparam logic [31:0] DEC_SUM =
      round_sum(IS_ODD ? CYCLES - STEP_IDX - 1 : CYCLES - STEP_IDX);
   localparam logic [1:0] ENC_KEY = IS_ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
   localparam logic [1:0] DEC_KEY = IS_ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

   logic        valid_ff;
   word_type    word_ff;
   word_type    word_in;
   logic        mod_first;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] sum;
   logic [31:0] key_sel;
   logic [31:0] tweak;
   logic [31:0] updated;

   // which half changes: even steps touch first on encrypt, second on decrypt
   assign mod_first = IS_ODD ? in_word.action : ~in_word.action;
   assign src       = mod_first ? in_word.second_word : in_word.first_word;
   assign dst       = mod_first ? in_word.first_word  : in_word.second_word;
   assign sum       = in_word.action ? DEC_SUM : ENC_SUM;
   assign key_sel   = in_word.action ? key[DEC_KEY] : key[ENC_KEY];

   // half-round arithmetic
   assign tweak   = mix_word(src) ^ (sum + key_sel);
   assign updated = in_word.action ? dst - tweak : dst + tweak;

   always_comb begin
      word_in = in_word;
      if (mod_first) begin
         word_in.first_word = updated;
      end else begin
         word_in.second_word = updated;
      end
   end

   // valid bit, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ rtl/xtea_skid.sv @@
// xtea_skid: output register with one skid entry behind the round pipeline
// depends on xtea_pkg; in_ready is a plain register output
module xtea_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  xtea_pkg::block_type in_block,
   output logic                in_ready,
   output logic                out_valid,
   output xtea_pkg::block_type out_block,
   input  logic                out_ready
);
   import xtea_pkg::*;

   logic      out_valid_ff;
   logic      out_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   block_type out_block_ff;
   block_type out_block_in;
   block_type skid_block_ff;
   block_type skid_block_in;
   logic      out_free;

   assign out_free = ~out_valid_ff | out_ready;

   // next-state for output and skid entries
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_block_in  = out_block_ff;
      skid_valid_in = skid_valid_ff;
      skid_block_in = skid_block_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            out_valid_in  = 1'b1;
            out_block_in  = skid_block_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = in_valid;
         out_block_in = in_block;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_block_in = in_block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_block_ff  <= out_block_in;
      skid_block_ff <= skid_block_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_block = out_block_ff;

endmodule

@@ rtl/xtea_checker.sv @@
// xtea_checker: port-level assertions for the xtea cipher unit, with bind
// depends on xtea_block_cipher_unit ports only
module xtea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_first_word,
   input logic [31:0] rsp_out_second_word,
   input logic        pready
);

   // output buffer is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // apb port never inserts wait states
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_first_word)
         && $stable(rsp_out_second_word))
      else $error("stalled result changed");

   // input backpressure only while a result is waiting
   a_ready_needs_out: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   // input backpressure only follows a receiver stall
   a_ready_after_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req_ready low without a prior stall");

endmodule

bind xtea_block_cipher_unit xtea_checker u_xtea_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_out_first_word  (rsp_out_first_word),
   .rsp_out_second_word (rsp_out_second_word),
   .pready              (pready)
);

@@ dv/xtea_block_cipher_unit_tb.sv @@
// xtea_block_cipher_unit_tb: self-checking bench for the pipelined xtea cipher unit
// depends on xtea_pkg and xtea_block_cipher_unit; a scoreboard class predicts each block
module xtea_block_cipher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xtea_pkg::*;

   localparam int   ROUNDS         = 32;
   localparam int   HOLD_CYCLES    = 500;
   localparam int   STALL_LIMIT    = 4000;
   localparam int   DRAIN_CYCLES   = 2 * ROUNDS + 8;
   localparam int   ITEMS_PER_PASS = 117;
   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   // expected cipher blocks, computed from a private copy of the key
   class cipher_scoreboard;
      logic [31:0] key_words [4];
      block_type   expected_q [$];
      int          mismatches;

      function new();
         key_words[KEY_WORD0_IDX] = KEY_WORD0_RESET;
         key_words[KEY_WORD1_IDX] = KEY_WORD1_RESET;
         key_words[KEY_WORD2_IDX] = KEY_WORD2_RESET;
         key_words[KEY_WORD3_IDX] = KEY_WORD3_RESET;
         mismatches = 0;
      endfunction

      function void load_key(logic [1:0] idx, logic [31:0] value);
         key_words[idx] = value;
      endfunction

      function logic [31:0] feistel_f(logic [31:0] v);
         return ({v[27:0], 4'b0000} ^ {5'b00000, v[31:5]}) + v;
      endfunction

      function block_type predict_block(logic decrypt, logic [31:0] a, logic [31:0] b);
         logic [31:0] v0;
         logic [31:0] v1;
         logic [31:0] sum;
         block_type   res;
         int          n;
         v0  = a;
         v1  = b;
         sum = '0;
         if (decrypt) begin
            // start from delta times the round count, wrapped to 32 bits
            for (n = 0; n < ROUNDS; n++) sum += XTEA_DELTA;
            for (n = 0; n < ROUNDS; n++) begin
               v1  -= feistel_f(v0) ^ (sum + key_words[sum[12:11]]);
               sum -= XTEA_DELTA;
               v0  -= feistel_f(v1) ^ (sum + key_words[sum[1:0]]);
            end
         end else begin
            for (n = 0; n < ROUNDS; n++) begin
               v0  += feistel_f(v1) ^ (sum + key_words[sum[1:0]]);
               sum += XTEA_DELTA;
               v1  += feistel_f(v0) ^ (sum + key_words[sum[12:11]]);
            end
         end
         res.first_word  = v0;
         res.second_word = v1;
         return res;
      endfunction

      function void note_word(logic decrypt, logic [31:0] a, logic [31:0] b);
         expected_q.push_back(predict_block(decrypt, a, b));
      endfunction

      function void check_block(logic [31:0] a, logic [31:0] b);
         block_type exp_blk;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h %h", $time, a, b);
            mismatches++;
         end else begin
            exp_blk = expected_q.pop_front();
            if (a !== exp_blk.first_word) begin
               $display("%0t: out_first_word expected %h actual %h",
                        $time, exp_blk.first_word, a);
               mismatches++;
            end
            if (b !== exp_blk.second_word) begin
               $display("%0t: out_second_word expected %h actual %h",
                        $time, exp_blk.second_word, b);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic                      req_action      = 1'b0;
   logic [31:0]               req_first_word  = '0;
   logic [31:0]               req_second_word = '0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic [31:0]               rsp_out_first_word;
   logic [31:0]               rsp_out_second_word;
   logic                      psel            = 1'b0;
   logic                      penable         = 1'b0;
   logic                      pwrite          = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr           = '0;
   logic [31:0]               pwdata          = '0;
   logic [31:0]               prdata;
   logic                      pready;

   cipher_scoreboard sb = new();
   int  idle_cycles  = 0;
   bit  quiet_send   = 1'b0;
   bit  quiet_recv   = 1'b0;
   bit  hold_pending = 1'b0;

   xtea_block_cipher_unit #(.CYCLE_COUNT(ROUNDS)) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_first_word      (req_first_word),
      .req_second_word     (req_second_word),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_first_word  (rsp_out_first_word),
      .rsp_out_second_word (rsp_out_second_word),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watch both handshakes and feed the scoreboard
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_word(req_action, req_first_word, req_second_word);
         if (rsp_valid && rsp_ready)
            sb.check_block(rsp_out_first_word, rsp_out_second_word);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // hang detection
   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // result side: random stalls, plus one long hold-off to back up the pipeline
   initial begin : result_sink
      int stall;
      bit hold_taken;
      hold_taken = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending && !hold_taken) begin
            stall      = HOLD_CYCLES;
            hold_taken = 1'b1;
         end else if (quiet_recv) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // offer one word and hold it until accepted
   task automatic send_word(input logic act, input logic [31:0] a, input logic [31:0] b);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_first_word  <= a;
      req_second_word <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // apb write, leaves the bus in its access phase
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.load_key(idx, value);
   endtask

   // apb read compared against the scoreboard's key copy
   task automatic csr_check(input logic [1:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== sb.key_words[idx]) begin
         $display("%0t: key register %0d expected %h actual %h",
                  $time, idx, sb.key_words[idx], prdata);
         sb.mismatches++;
      end
   endtask

   task automatic csr_idle();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // load a whole key, then read all four registers back
   task automatic program_key(input logic [31:0] k0, input logic [31:0] k1,
                              input logic [31:0] k2, input logic [31:0] k3);
      csr_write(KEY_WORD0_IDX, k0);
      csr_write(KEY_WORD1_IDX, k1);
      csr_write(KEY_WORD2_IDX, k2);
      csr_write(KEY_WORD3_IDX, k3);
      csr_check(KEY_WORD0_IDX);
      csr_check(KEY_WORD1_IDX);
      csr_check(KEY_WORD2_IDX);
      csr_check(KEY_WORD3_IDX);
      csr_idle();
   endtask

   // random data half, weighted toward corner patterns
   function automatic logic [31:0] pick_half();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // encrypt a block, then decrypt its predicted ciphertext
   task automatic send_round_trip(input logic [31:0] a, input logic [31:0] b);
      block_type ct;
      ct = sb.predict_block(ACTION_ENCRYPT, a, b);
      send_word(ACTION_ENCRYPT, a, b);
      send_word(ACTION_DECRYPT, ct.first_word, ct.second_word);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 4) == 0 && n + 1 < count) begin
            send_round_trip(pick_half(), pick_half());
            n += 2;
         end else begin
            send_word(1'($urandom_range(0, 1)), pick_half(), pick_half());
            n++;
         end
      end
      req_valid <= 1'b0;
      wait_drained();
   endtask

   task automatic run_pass(input int count);
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
      run_random(count);
   endtask

   // stimulus
   initial begin : stimulus
      int p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // built-in key after reset
      csr_check(KEY_WORD0_IDX);
      csr_check(KEY_WORD1_IDX);
      csr_check(KEY_WORD2_IDX);
      csr_check(KEY_WORD3_IDX);
      csr_idle();

      // directed words: extremes, both actions, alternating patterns
      send_word(ACTION_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_word(ACTION_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACTION_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_word(ACTION_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(ACTION_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(ACTION_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(ACTION_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_word(ACTION_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      send_word(ACTION_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
      send_word(ACTION_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
      send_round_trip(32'h0123_4567, 32'h89AB_CDEF);
      send_round_trip($urandom, $urandom);
      req_valid <= 1'b0;
      wait_drained();

      // back-pressure pass: sender never idles while the sink holds off
      quiet_send   = 1'b1;
      quiet_recv   = 1'b0;
      hold_pending = 1'b1;
      run_random(ITEMS_PER_PASS);

      // key extremes
      program_key('0, '0, '0, '0);
      run_pass(ITEMS_PER_PASS);
      program_key('1, '1, '1, '1);
      run_pass(ITEMS_PER_PASS);
      program_key('0, '1, '0, '1);
      run_pass(ITEMS_PER_PASS);

      // random keys
      for (p = 0; p < 4; p++) begin
         program_key($urandom, $urandom, $urandom, $urandom);
         run_pass(ITEMS_PER_PASS);
      end

      // let anything stray come out before the verdict
      quiet_recv = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
